/* sv/siud_pkg.sv */
// Shared types and codes for the set intersect/union/difference block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package siud_pkg;

    localparam int DATA_W = 32;

    // command codes carried in the input word
    typedef enum logic [2:0] {
        CMD_CLEAR      = 3'd0,
        CMD_LOAD_A     = 3'd1,
        CMD_LOAD_B     = 3'd2,
        CMD_INTERSECT  = 3'd3,
        CMD_UNION      = 3'd4,
        CMD_DIFFERENCE = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic                     last;
        logic                     empty_result;
        logic                     overflow;
    } t_out_word;

    // sequencer -> output register
    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_push;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OUTER,
        ST_CAND,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_PUT,
        ST_COPY,
        ST_COPY_RD,
        ST_FLUSH
    } t_state;

endpackage

/* sv/siud_store.sv */
// Value store: one write port, one read port, registered read data.
// Depends on siud_pkg for the data width.
`timescale 1ns / 1ps

module siud_store #(
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic signed [siud_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]                     i_raddr,
    output logic signed [siud_pkg::DATA_W-1:0] o_rdata
);
    import siud_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/siud_outreg.sv */
// Output register that decouples the sequencer from the result consumer.
// Depends on siud_pkg (t_push, t_out_word).
`timescale 1ns / 1ps

module siud_outreg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  siud_pkg::t_push     i_push,
    output logic                o_free,
    output logic                o_out_valid,
    output siud_pkg::t_out_word o_out_word,
    input  logic                i_out_ready
);
    import siud_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_word <= i_push.word;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

/* sv/siud_seq.sv */
// Command sequencer: loads, clears and the compare loops over both stores.
// Depends on siud_pkg; drives the two siud_store memories and siud_outreg.
`timescale 1ns / 1ps

module siud_seq #(
    parameter  int CAPACITY = 16,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  siud_pkg::t_in_word                 i_in_word,
    output logic                               o_a_we,
    output logic [AW-1:0]                      o_a_waddr,
    output logic [AW-1:0]                      o_a_raddr,
    input  logic signed [siud_pkg::DATA_W-1:0] i_a_rdata,
    output logic                               o_b_we,
    output logic [AW-1:0]                      o_b_waddr,
    output logic [AW-1:0]                      o_b_raddr,
    input  logic signed [siud_pkg::DATA_W-1:0] i_b_rdata,
    input  logic                               i_out_free,
    output siud_pkg::t_push                    o_push
);
    import siud_pkg::*;

    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

    t_state r_state, n_state;
    t_cmd   r_op, n_op;
    logic [CW-1:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j, r_cj, n_cj;
    logic          r_cv, n_cv, r_hit, n_hit, r_copy, n_copy;
    logic          r_ovf, n_ovf, r_pend_v, n_pend_v;
    logic signed [DATA_W-1:0] r_cand, n_cand, r_pend_val, n_pend_val;

    logic          w_accept, w_is_set, w_outer_more, w_copy_more;
    logic          w_hit_now, w_emit, w_put_go;
    logic [CW-1:0] w_cj_ext;

    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_is_set    = (i_in_word.command == CMD_INTERSECT) ||
                         (i_in_word.command == CMD_UNION) ||
                         (i_in_word.command == CMD_DIFFERENCE);
    assign w_outer_more = (r_op == CMD_UNION) ? (r_i < r_cnt_b) : (r_i < r_cnt_a);
    assign w_copy_more  = r_i < r_cnt_a;
    assign w_cj_ext     = CW'(r_cj);

    // union: candidate from B must be absent from all of A and from later B
    always_comb begin
        if (!r_cv) begin
            w_hit_now = 1'b0;
        end else if (r_op == CMD_UNION) begin
            w_hit_now = ((w_cj_ext < r_cnt_a) && (i_a_rdata == r_cand)) ||
                        ((w_cj_ext > r_i) && (w_cj_ext < r_cnt_b) &&
                         (i_b_rdata == r_cand));
        end else begin
            w_hit_now = (w_cj_ext < r_cnt_b) && (i_b_rdata == r_cand);
        end
    end

    assign w_emit   = (r_op == CMD_INTERSECT) ? r_hit : !r_hit;
    assign w_put_go = !r_pend_v || i_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (w_accept && w_is_set) n_state = ST_OUTER;
            ST_OUTER: begin
                if (w_outer_more)            n_state = ST_CAND;
                else if (r_op == CMD_UNION)  n_state = ST_COPY;
                else                         n_state = ST_FLUSH;
            end
            ST_CAND:    n_state = ST_SCAN;
            ST_SCAN:    if (r_j == LAST_IDX) n_state = ST_DRAIN;
            ST_DRAIN:   n_state = ST_DECIDE;
            ST_DECIDE:  n_state = w_emit ? ST_PUT : ST_OUTER;
            ST_PUT:     if (w_put_go) n_state = r_copy ? ST_COPY : ST_OUTER;
            ST_COPY:    n_state = w_copy_more ? ST_COPY_RD : ST_FLUSH;
            ST_COPY_RD: n_state = ST_PUT;
            ST_FLUSH:   if (i_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_op       = r_op;
        n_cnt_a    = r_cnt_a;
        n_cnt_b    = r_cnt_b;
        n_i        = r_i;
        n_j        = r_j;
        n_cj       = r_cj;
        n_cv       = r_cv;
        n_hit      = r_hit;
        n_copy     = r_copy;
        n_ovf      = r_ovf;
        n_pend_v   = r_pend_v;
        n_cand     = r_cand;
        n_pend_val = r_pend_val;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_word.command)
                        CMD_CLEAR: begin
                            n_cnt_a = '0;
                            n_cnt_b = '0;
                        end
                        CMD_LOAD_A: begin
                            if (r_cnt_a < CAP_CNT) n_cnt_a = r_cnt_a + 1'b1;
                            else                   n_ovf   = 1'b1;
                        end
                        CMD_LOAD_B: begin
                            if (r_cnt_b < CAP_CNT) n_cnt_b = r_cnt_b + 1'b1;
                            else                   n_ovf   = 1'b1;
                        end
                        CMD_INTERSECT, CMD_UNION, CMD_DIFFERENCE: begin
                            n_op     = t_cmd'(i_in_word.command);
                            n_i      = '0;
                            n_pend_v = 1'b0;
                            n_copy   = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_OUTER: begin
                if (!w_outer_more && (r_op == CMD_UNION)) begin
                    n_i    = '0;
                    n_copy = 1'b1;
                end
            end
            ST_CAND: begin
                n_cand = (r_op == CMD_UNION) ? i_b_rdata : i_a_rdata;
                n_j    = '0;
                n_hit  = 1'b0;
                n_cv   = 1'b0;
            end
            ST_SCAN: begin
                n_cv  = 1'b1;
                n_cj  = r_j;
                n_hit = r_hit || w_hit_now;
                if (r_j != LAST_IDX) n_j = r_j + 1'b1;
            end
            ST_DRAIN: begin
                n_hit = r_hit || w_hit_now;
                n_cv  = 1'b0;
            end
            ST_DECIDE: begin
                if (!w_emit) n_i = r_i + 1'b1;
            end
            ST_PUT: begin
                if (w_put_go) begin
                    n_pend_v   = 1'b1;
                    n_pend_val = r_cand;
                    n_i        = r_i + 1'b1;
                end
            end
            ST_COPY_RD: n_cand = i_a_rdata;
            ST_FLUSH:   if (i_out_free) n_pend_v = 1'b0;
            default: ;
        endcase
    end

    // outputs: memory control and result push
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        o_a_we     = w_accept && (i_in_word.command == CMD_LOAD_A) && (r_cnt_a < CAP_CNT);
        o_b_we     = w_accept && (i_in_word.command == CMD_LOAD_B) && (r_cnt_b < CAP_CNT);
        o_a_waddr  = r_cnt_a[AW-1:0];
        o_b_waddr  = r_cnt_b[AW-1:0];
        o_a_raddr  = '0;
        o_b_raddr  = '0;
        o_push     = '0;
        o_push.word.overflow = r_ovf;
        unique case (r_state)
            ST_OUTER: begin
                o_a_raddr = r_i[AW-1:0];
                o_b_raddr = r_i[AW-1:0];
            end
            ST_SCAN: begin
                o_a_raddr = r_j;
                o_b_raddr = r_j;
            end
            ST_COPY: o_a_raddr = r_i[AW-1:0];
            ST_PUT: begin
                o_push.valid          = r_pend_v && i_out_free;
                o_push.word.value_res = r_pend_val;
            end
            ST_FLUSH: begin
                o_push.valid             = i_out_free;
                o_push.word.value_res    = r_pend_v ? r_pend_val : '0;
                o_push.word.last         = 1'b1;
                o_push.word.empty_result = !r_pend_v;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= CMD_CLEAR;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_cj     <= '0;
            r_cv     <= 1'b0;
            r_hit    <= 1'b0;
            r_copy   <= 1'b0;
            r_ovf    <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_i      <= n_i;
            r_j      <= n_j;
            r_cj     <= n_cj;
            r_cv     <= n_cv;
            r_hit    <= n_hit;
            r_copy   <= n_copy;
            r_ovf    <= n_ovf;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand     <= n_cand;
        r_pend_val <= n_pend_val;
    end

endmodule

/* sv/set_intersect_union_difference.sv */
// Set intersect/union/difference over two stores. Load and clear words are taken
// without leaving idle; a set command scans both stores, one read per cycle each,
// for every outer entry, and union adds a copy pass over store A. One command is
// handled at a time; the next word is taken once the final result is in the output
// register. Synchronous active-low reset clears counts and the overflow flag; store
// contents stay undefined until loaded.
`timescale 1ns / 1ps

module set_intersect_union_difference #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  siud_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output siud_pkg::t_out_word o_out_word
);
    import siud_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // store A / store B ports
    logic                     w_a_we, w_b_we;
    logic [AW-1:0]            w_a_waddr, w_a_raddr, w_b_waddr, w_b_raddr;
    logic signed [DATA_W-1:0] w_a_rdata, w_b_rdata;

    // sequencer to output register
    t_push w_push;
    logic  w_out_free;

    // Stores are only written while the sequencer is idle and only scanned while it
    // is busy, so reads and writes never overlap on an entry: no forwarding needed.
    siud_store #(.DEPTH(CAPACITY)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_a_waddr),
        .i_wdata (i_in_word.value),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    siud_store #(.DEPTH(CAPACITY)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_b_waddr),
        .i_wdata (i_in_word.value),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    // Sequencer: per outer entry, fetch the candidate, sweep both stores one entry
    // a cycle, then decide. One result word is held back so the final one can be
    // flagged last once the loop ends.
    siud_seq #(.CAPACITY(CAPACITY)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_a_we     (w_a_we),
        .o_a_waddr  (w_a_waddr),
        .o_a_raddr  (w_a_raddr),
        .i_a_rdata  (w_a_rdata),
        .o_b_we     (w_b_we),
        .o_b_waddr  (w_b_waddr),
        .o_b_raddr  (w_b_raddr),
        .i_b_rdata  (w_b_rdata),
        .i_out_free (w_out_free),
        .o_push     (w_push)
    );

    // Output register: overflow is captured per word, so a later load that sets
    // the flag does not disturb a word still waiting for the consumer.
    siud_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_ready (i_out_ready)
    );

`ifndef ASSERT_OFF
    // never overwrite a result word the consumer has not taken
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> w_out_free)
        else $error("result pushed into occupied output register");

    // no results are produced while new words are being accepted
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_push.valid)
        else $error("result pushed while idle");

    // an empty result is always the only, and so final, word
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.valid && w_push.word.empty_result) |-> w_push.word.last)
        else $error("empty result not flagged last");

    // the final word of a command returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.valid && w_push.word.last) |=> o_in_ready)
        else $error("sequencer busy after final result");
`endif

endmodule
